>>> rtl/dte_pkg.sv
// dte_pkg: shared types and codes for the descriptor table engine
// request modes, result status codes, controller states and the
// command/status structs between controller and datapath
`timescale 1ns / 1ps
`default_nettype none

package dte_pkg;

    // pin count storage width, fixed by the largest pin limit
    localparam int PIN_W = 7;

    // request modes
    typedef enum logic [2:0] {
        MODE_ALLOC   = 3'd0,
        MODE_RELEASE = 3'd1,
        MODE_PIN     = 3'd2,
        MODE_UNPIN   = 3'd3,
        MODE_LOOKUP  = 3'd4,
        MODE_QUERY   = 3'd5
    } t_mode;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_INVALID = 3'd2,
        ST_BUSY    = 3'd3,
        ST_FAULT   = 3'd4
    } t_status;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_EXEC,
        S_SCAN,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr_we;       // clear one table entry, advance clear pointer
        logic capture;      // load the request registers
        logic rd_single;    // read the addressed slot
        logic exec_single;  // finish release / pin / unpin / lookup
        logic scan_start;   // set up the slot scan
        logic scan_step;    // issue the next scan read
        logic scan_end;     // finish allocate / query
        logic load_out;     // move the finished result into the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;     // clear pointer is on the last entry
        logic req_scan;     // request needs a slot scan
        logic scan_hit;     // current scan candidate matches
        logic scan_miss;    // every slot checked, none matched
        logic out_free;     // output register can take a result
    } t_dp_stat;

endpackage

`default_nettype wire

>>> rtl/dte_ctrl.sv
// dte_ctrl: sequencing state machine for the descriptor table engine
// drives the datapath through t_dp_cmd and watches t_dp_stat (dte_pkg)
`timescale 1ns / 1ps
`default_nettype none

module dte_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  dte_pkg::t_dp_stat i_stat,
    output dte_pkg::t_dp_cmd  o_cmd
);
    import dte_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.req_scan) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end else begin
                    o_cmd.rd_single = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec_single = 1'b1;
                n_state           = S_OUT;
            end
            S_SCAN: begin
                if (i_stat.scan_hit || i_stat.scan_miss) begin
                    o_cmd.scan_end = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/dte_dp.sv
// dte_dp: datapath of the descriptor table engine
// slot table memory, request registers, next-fit scan, result and output registers
// commanded by dte_ctrl through the dte_pkg structs
`timescale 1ns / 1ps
`default_nettype none

module dte_dp #(
    parameter int SLOTS      = 64,
    parameter int PIN_LIMIT  = 126,
    parameter int FS_ID_BITS = 8
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  dte_pkg::t_dp_cmd  i_cmd,
    output dte_pkg::t_dp_stat o_stat,
    input  wire  [2:0]        i_mode,
    input  wire  [5:0]        i_slot_index,
    input  wire  [63:0]       i_inode_number,
    input  wire  [7:0]        i_fs_instance,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output logic [2:0]        o_status,
    output logic [5:0]        o_out_slot,
    output logic [63:0]       o_out_inode,
    output logic [7:0]        o_out_fs,
    output logic              o_inode_in_use
);
    import dte_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef struct packed {
        logic                  used;
        logic [PIN_W-1:0]      pin;
        logic [FS_ID_BITS-1:0] fs;
        logic [63:0]           inode;
    } t_entry;

    // slot table
    t_entry mem [SLOTS];
    t_entry r_rd;

    // request registers
    t_mode                 r_mode;
    logic [5:0]            r_idx;
    logic [63:0]           r_ino;
    logic [FS_ID_BITS-1:0] r_fs;

    // control registers
    logic [IDX_W-1:0] r_clr_addr;
    logic [IDX_W-1:0] r_search;
    logic [IDX_W-1:0] r_scan_addr;
    logic [CNT_W-1:0] r_issued;
    logic [IDX_W-1:0] r_chk_addr;
    logic             r_chk_vld;

    // result staging and output register
    t_status     r_res_status;
    logic [5:0]  r_res_slot;
    logic [63:0] r_res_ino;
    logic [7:0]  r_res_fs;
    logic        r_res_inuse;
    logic        r_out_vld;
    t_status     r_out_status;
    logic [5:0]  r_out_slot;
    logic [63:0] r_out_ino;
    logic [7:0]  r_out_fs;
    logic        r_out_inuse;

    logic [IDX_W-1:0] idx_addr;
    logic             idx_bad;
    logic             is_alloc;
    logic             hit;
    logic             miss;
    logic             all_issued;
    logic [IDX_W-1:0] start_addr;
    logic [IDX_W-1:0] next_scan;
    t_status          ex_status;
    logic             ex_we;
    t_entry           ex_entry;
    logic             ex_out;
    logic             alloc_we;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    t_entry           mem_wd;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    t_entry           alloc_entry;

    // request capture on the input beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= t_mode'(i_mode);
            r_idx  <= i_slot_index;
            r_ino  <= i_inode_number;
            r_fs   <= FS_ID_BITS'(i_fs_instance);
        end
    end

    assign idx_addr   = IDX_W'(r_idx);
    assign idx_bad    = !(32'(r_idx) < 32'(SLOTS));
    assign is_alloc   = (r_mode == MODE_ALLOC);
    assign all_issued = (r_issued == CNT_W'(SLOTS));
    assign start_addr = (r_search == LAST_IDX) ? '0 : r_search + 1'b1;
    assign next_scan  = (r_scan_addr == LAST_IDX) ? '0 : r_scan_addr + 1'b1;

    // scan candidate check
    always_comb begin
        if (is_alloc) begin
            hit = r_chk_vld && !r_rd.used;
        end else begin
            hit = r_chk_vld && r_rd.used && (r_rd.inode == r_ino) && (r_rd.fs == r_fs);
        end
        miss = !r_chk_vld && all_issued;
    end

    // single-slot operations on the read entry
    always_comb begin
        ex_status = ST_OK;
        ex_we     = 1'b0;
        ex_out    = 1'b0;
        ex_entry  = r_rd;
        unique case (r_mode)
            MODE_RELEASE: begin
                if (idx_bad || !r_rd.used) begin
                    ex_status = ST_INVALID;
                end else if (r_rd.pin != '0) begin
                    ex_status = ST_BUSY;
                end else begin
                    ex_we         = 1'b1;
                    ex_entry.used = 1'b0;
                end
            end
            MODE_PIN: begin
                if (idx_bad || !r_rd.used) begin
                    ex_status = ST_INVALID;
                end else if (r_rd.pin >= PIN_W'(PIN_LIMIT)) begin
                    ex_status = ST_FAULT;
                end else begin
                    ex_we        = 1'b1;
                    ex_out       = 1'b1;
                    ex_entry.pin = r_rd.pin + 1'b1;
                end
            end
            MODE_UNPIN: begin
                if (idx_bad || !r_rd.used) begin
                    ex_status = ST_INVALID;
                end else if (r_rd.pin == '0) begin
                    ex_status = ST_FAULT;
                end else begin
                    ex_we        = 1'b1;
                    ex_entry.pin = r_rd.pin - 1'b1;
                end
            end
            MODE_LOOKUP: begin
                if (idx_bad || !r_rd.used) begin
                    ex_status = ST_INVALID;
                end else begin
                    ex_out = 1'b1;
                end
            end
            default: begin
                ex_status = ST_INVALID;
            end
        endcase
    end

    // new entry for a granted slot
    always_comb begin
        alloc_entry       = '0;
        alloc_entry.used  = 1'b1;
        alloc_entry.fs    = r_fs;
        alloc_entry.inode = r_ino;
    end

    assign alloc_we = i_cmd.scan_end && is_alloc && hit;

    // table write port select
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_clr_addr;
        mem_wd = '0;
        priority if (i_cmd.clr_we) begin
            mem_we = 1'b1;
        end else if (i_cmd.exec_single) begin
            mem_we = ex_we;
            mem_wa = idx_addr;
            mem_wd = ex_entry;
        end else if (alloc_we) begin
            mem_we = 1'b1;
            mem_wa = r_chk_addr;
            mem_wd = alloc_entry;
        end else begin
            mem_we = 1'b0;
        end
    end

    // table read port select
    assign rd_en   = i_cmd.rd_single || (i_cmd.scan_step && !all_issued);
    assign rd_addr = i_cmd.rd_single ? idx_addr : r_scan_addr;

    // slot table memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    // clear pointer and next-fit pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_search   <= '0;
        end else begin
            if (i_cmd.clr_we) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (alloc_we) begin
                r_search <= r_chk_addr;
            end
        end
    end

    // scan address, issue count and candidate tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_addr <= '0;
            r_issued    <= '0;
            r_chk_addr  <= '0;
            r_chk_vld   <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_scan_addr <= start_addr;
            r_issued    <= '0;
            r_chk_vld   <= 1'b0;
        end else if (i_cmd.scan_step) begin
            if (!all_issued) begin
                r_scan_addr <= next_scan;
                r_issued    <= r_issued + 1'b1;
                r_chk_addr  <= r_scan_addr;
                r_chk_vld   <= 1'b1;
            end else begin
                r_chk_vld <= 1'b0;
            end
        end
    end

    // result staging
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec_single) begin
            r_res_status <= ex_status;
            r_res_slot   <= '0;
            r_res_ino    <= ex_out ? r_rd.inode : '0;
            r_res_fs     <= ex_out ? 8'(r_rd.fs) : '0;
            r_res_inuse  <= 1'b0;
        end else if (i_cmd.scan_end) begin
            r_res_ino <= '0;
            r_res_fs  <= '0;
            if (is_alloc) begin
                r_res_status <= hit ? ST_OK : ST_FULL;
                r_res_slot   <= hit ? 6'(r_chk_addr) : '0;
                r_res_inuse  <= 1'b0;
            end else begin
                r_res_status <= ST_OK;
                r_res_slot   <= '0;
                r_res_inuse  <= hit;
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
            r_out_ino    <= r_res_ino;
            r_out_fs     <= r_res_fs;
            r_out_inuse  <= r_res_inuse;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_status       = r_out_status;
    assign o_out_slot     = r_out_slot;
    assign o_out_inode    = r_out_ino;
    assign o_out_fs       = r_out_fs;
    assign o_inode_in_use = r_out_inuse;

    // status to the controller
    always_comb begin
        o_stat           = '0;
        o_stat.clr_last  = (r_clr_addr == LAST_IDX);
        o_stat.req_scan  = (r_mode == MODE_ALLOC) || (r_mode == MODE_QUERY);
        o_stat.scan_hit  = hit;
        o_stat.scan_miss = miss;
        o_stat.out_free  = !r_out_vld || i_out_ready;
    end

`ifndef SYNTHESIS
    // a result never overwrites one that has not been taken
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_vld || i_out_ready))
        else $error("output register overwritten while full");

    // a scan cannot both match and run out
    a_hit_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_chk_vld && miss))
        else $error("scan hit and miss together");

    // never more reads than slots in one scan
    a_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_issued) <= 32'(SLOTS))
        else $error("scan issue count past slot count");

    // a granted slot becomes the next-fit pointer
    a_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alloc_we |=> (r_search == $past(r_chk_addr)))
        else $error("next-fit pointer not moved to granted slot");

    // a grant only goes to a slot that read back free
    a_grant_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alloc_we |-> (r_chk_vld && !r_rd.used))
        else $error("slot granted while in use");
`endif

endmodule

`default_nettype wire

>>> rtl/descriptor_table_engine.sv
// descriptor_table_engine: slot table with next-fit allocate, release, pin,
// unpin, lookup and inode query
// top level joining dte_ctrl and dte_dp, types from dte_pkg
//
// usage:
// - request channel i_in_valid / o_in_ready carries one beat per request:
//   mode, slot index, inode number and filesystem instance
// - result channel o_out_valid / i_out_ready returns exactly one beat per
//   request, in request order
// - one request is in work at a time; release, pin, unpin, lookup and bad
//   requests pass through the dispatch and execute states to a loaded result,
//   and the next request is taken only once that result has been loaded
// - allocate and inode query walk the table one slot per cycle through the
//   single read port; allocate stops at the first
//   free slot after the next-fit pointer, a query at the first match
// - after reset the table is cleared one entry per cycle: o_in_ready stays
//   low until every entry has been cleared
// - the result sits in an output register, so the next request is taken
//   while a result waits; if the receiver stalls, that next result holds
//   inside and o_in_ready stays low until the output register frees up
`timescale 1ns / 1ps
`default_nettype none

module descriptor_table_engine #(
    parameter int SLOTS      = 64,
    parameter int PIN_LIMIT  = 126,
    parameter int FS_ID_BITS = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [2:0]  i_mode,
    input  wire  [5:0]  i_slot_index,
    input  wire  [63:0] i_inode_number,
    input  wire  [7:0]  i_fs_instance,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [2:0]  o_status,
    output logic [5:0]  o_out_slot,
    output logic [63:0] o_out_inode,
    output logic [7:0]  o_out_fs,
    output logic        o_inode_in_use
);
    import dte_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencing
    dte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // table, scan and result registers
    dte_dp #(
        .SLOTS      (SLOTS),
        .PIN_LIMIT  (PIN_LIMIT),
        .FS_ID_BITS (FS_ID_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_mode         (i_mode),
        .i_slot_index   (i_slot_index),
        .i_inode_number (i_inode_number),
        .i_fs_instance  (i_fs_instance),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_out_slot     (o_out_slot),
        .o_out_inode    (o_out_inode),
        .o_out_fs       (o_out_fs),
        .o_inode_in_use (o_inode_in_use)
    );

endmodule

`default_nettype wire

>>> bench/slot_table_checker.sv
// slot_table_checker: watches the request and result channels of the descriptor table engine
// keeps its own copy of the slot table, predicts each result beat and compares it
// depends on dte_pkg for the mode and status codes
`timescale 1ns / 1ps
module slot_table_checker #(
    parameter int SLOTS      = 64,
    parameter int PIN_LIMIT  = 126,
    parameter int FS_ID_BITS = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    input  wire         i_in_ready,
    input  wire  [2:0]  i_mode,
    input  wire  [5:0]  i_slot_index,
    input  wire  [63:0] i_inode_number,
    input  wire  [7:0]  i_fs_instance,
    input  wire         i_out_valid,
    input  wire         i_out_ready,
    input  wire  [2:0]  i_status,
    input  wire  [5:0]  i_out_slot,
    input  wire  [63:0] i_out_inode,
    input  wire  [7:0]  i_out_fs,
    input  wire         i_inode_in_use,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_compared
);
    import dte_pkg::*;

    localparam logic [7:0] FS_MASK = 8'((1 << FS_ID_BITS) - 1);
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot;
        logic [63:0] inode;
        logic [7:0]  fs;
        logic        in_use;
    } t_slot_reply;

    // shadow copy of the slot table
    logic             slot_live [SLOTS];
    logic [PIN_W-1:0] pin_depth [SLOTS];
    logic [63:0]      slot_ino  [SLOTS];
    logic [7:0]       slot_fsid [SLOTS];
    int unsigned      next_fit;

    t_slot_reply replies_due [$];
    t_slot_reply due;
    t_slot_reply seen;
    int          fail_total = 0;
    int          compared_total = 0;

    // apply one request to the shadow table and return the reply it earns
    function automatic t_slot_reply apply_request(logic [2:0] mode, logic [5:0] idx,
                                                  logic [63:0] ino, logic [7:0] fs_raw);
        t_slot_reply r;
        int unsigned pos;
        logic [7:0]  fs_key;
        logic        live;
        r = '0;
        fs_key = fs_raw & FS_MASK;
        live = (idx < SLOTS) && slot_live[idx];
        r.status = ST_OK;
        case (mode)
            MODE_ALLOC: begin
                // next-fit: start after the pointer, wrap, try the pointer slot last
                r.status = ST_FULL;
                pos = next_fit;
                for (int n = 0; n < SLOTS; n++) begin
                    pos = (pos + 1 >= SLOTS) ? 0 : pos + 1;
                    if (r.status == ST_FULL && !slot_live[pos]) begin
                        slot_live[pos] = 1'b1;
                        pin_depth[pos] = '0;
                        slot_ino[pos] = ino;
                        slot_fsid[pos] = fs_key;
                        next_fit = pos;
                        r.status = ST_OK;
                        r.slot = pos[5:0];
                    end
                end
            end
            MODE_RELEASE: begin
                if (!live) r.status = ST_INVALID;
                else if (pin_depth[idx] != 0) r.status = ST_BUSY;
                else slot_live[idx] = 1'b0;
            end
            MODE_PIN: begin
                if (!live) begin
                    r.status = ST_INVALID;
                end else if (pin_depth[idx] >= PIN_LIMIT) begin
                    r.status = ST_FAULT;
                end else begin
                    pin_depth[idx] = pin_depth[idx] + 1'b1;
                    r.inode = slot_ino[idx];
                    r.fs = slot_fsid[idx];
                end
            end
            MODE_UNPIN: begin
                if (!live) r.status = ST_INVALID;
                else if (pin_depth[idx] == 0) r.status = ST_FAULT;
                else pin_depth[idx] = pin_depth[idx] - 1'b1;
            end
            MODE_LOOKUP: begin
                if (!live) begin
                    r.status = ST_INVALID;
                end else begin
                    r.inode = slot_ino[idx];
                    r.fs = slot_fsid[idx];
                end
            end
            MODE_QUERY: begin
                for (int n = 0; n < SLOTS; n++) begin
                    if (slot_live[n] && slot_ino[n] == ino && slot_fsid[n] == fs_key)
                        r.in_use = 1'b1;
                end
            end
            default: begin
                r.status = ST_INVALID;
            end
        endcase
        return r;
    endfunction

    // result beats are matched first, then the request beat of the same edge is predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_live[i] = 1'b0;
                pin_depth[i] = '0;
                slot_ino[i] = '0;
                slot_fsid[i] = '0;
            end
            next_fit = 0;
            replies_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                seen.status = i_status;
                seen.slot = i_out_slot;
                seen.inode = i_out_inode;
                seen.fs = i_out_fs;
                seen.in_use = i_inode_in_use;
                compared_total++;
                if (replies_due.size() == 0) begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT)
                        $display("result beat with nothing outstanding: status %0d slot %0d",
                                 seen.status, seen.slot);
                end else begin
                    due = replies_due.pop_front();
                    if (seen.status !== due.status || seen.slot !== due.slot ||
                        seen.inode !== due.inode || seen.fs !== due.fs ||
                        seen.in_use !== due.in_use) begin
                        fail_total++;
                        if (fail_total <= REPORT_LIMIT) begin
                            $display("beat %0d expected: st %0d slot %0d ino %h fs %h use %0b",
                                     compared_total, due.status, due.slot, due.inode, due.fs,
                                     due.in_use);
                            $display("beat %0d actual:   st %0d slot %0d ino %h fs %h use %0b",
                                     compared_total, seen.status, seen.slot, seen.inode,
                                     seen.fs, seen.in_use);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                replies_due.push_back(apply_request(i_mode, i_slot_index, i_inode_number,
                                                    i_fs_instance));
        end
        o_pending <= replies_due.size();
        o_fail_count <= fail_total;
        o_compared <= compared_total;
    end

endmodule

>>> bench/tb_descriptor_table_engine.sv
// tb_descriptor_table_engine: request stimulus, result-side stalls and verdict
// depends on descriptor_table_engine, slot_table_checker and dte_pkg
`timescale 1ns / 1ps
module tb_descriptor_table_engine;
    import dte_pkg::*;

    localparam int SLOTS        = 64;
    localparam int PIN_LIMIT    = 126;
    localparam int FS_ID_BITS   = 8;
    localparam logic [2:0] MODE_UNDEF_LO = 3'd6;
    localparam logic [2:0] MODE_UNDEF_HI = 3'd7;
    localparam int TOTAL_ITEMS  = 1770;
    localparam int QUIET_TAIL   = 200;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE_CYCLES = SLOTS + 16;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int POOL_DEPTH   = 16;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  req_mode = '0;
    logic [5:0]  req_slot = '0;
    logic [63:0] req_inode = '0;
    logic [7:0]  req_fs = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    logic [2:0]  rsp_status;
    logic [5:0]  rsp_slot;
    logic [63:0] rsp_inode;
    logic [7:0]  rsp_fs;
    logic        rsp_in_use;

    int fail_count;
    int pending;
    int compared;

    // stimulus bookkeeping
    bit          gaps_on = 1'b1;
    bit          stalls_on = 1'b1;
    bit          long_hold_req = 1'b0;
    int          sent_total = 0;
    int          mode_count [8];
    logic [63:0] pool_inode [POOL_DEPTH];
    logic [7:0]  pool_fs [POOL_DEPTH];
    int          pool_wr = 0;
    int          cycle_count = 0;

    descriptor_table_engine #(
        .SLOTS      (SLOTS),
        .PIN_LIMIT  (PIN_LIMIT),
        .FS_ID_BITS (FS_ID_BITS)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_mode         (req_mode),
        .i_slot_index   (req_slot),
        .i_inode_number (req_inode),
        .i_fs_instance  (req_fs),
        .o_out_valid    (rsp_valid),
        .i_out_ready    (rsp_ready),
        .o_status       (rsp_status),
        .o_out_slot     (rsp_slot),
        .o_out_inode    (rsp_inode),
        .o_out_fs       (rsp_fs),
        .o_inode_in_use (rsp_in_use)
    );

    slot_table_checker #(
        .SLOTS      (SLOTS),
        .PIN_LIMIT  (PIN_LIMIT),
        .FS_ID_BITS (FS_ID_BITS)
    ) checker_i (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_mode         (req_mode),
        .i_slot_index   (req_slot),
        .i_inode_number (req_inode),
        .i_fs_instance  (req_fs),
        .i_out_valid    (rsp_valid),
        .i_out_ready    (rsp_ready),
        .i_status       (rsp_status),
        .i_out_slot     (rsp_slot),
        .i_out_inode    (rsp_inode),
        .i_out_fs       (rsp_fs),
        .i_inode_in_use (rsp_in_use),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_compared     (compared)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // cycle limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial begin
        @(posedge clk);
        forever begin
            if (long_hold_req) begin
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_req = 1'b0;
            end else if (stalls_on && $urandom_range(0, 5) == 0) begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // offer one request beat, optionally after an idle burst, and wait for acceptance
    task automatic send_request(input logic [2:0] mode, input logic [5:0] idx,
                                input logic [63:0] ino, input logic [7:0] fs);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_mode <= mode;
        req_slot <= idx;
        req_inode <= ino;
        req_fs <= fs;
        if (mode == MODE_ALLOC) begin
            pool_inode[pool_wr] = ino;
            pool_fs[pool_wr] = fs;
            pool_wr = (pool_wr + 1) % POOL_DEPTH;
        end
        mode_count[mode]++;
        sent_total++;
        do @(posedge clk); while (!in_ready);
    endtask

    // stop offering and wait until every outstanding result has come back
    task automatic wait_results_done();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // inode / instance pair: a recently allocated one, an extreme, or fully random
    task automatic random_payload(input bit from_pool, output logic [63:0] ino,
                                  output logic [7:0] fs);
        int sel;
        int kind;
        sel = $urandom_range(0, POOL_DEPTH - 1);
        kind = from_pool ? 0 : $urandom_range(0, 3);
        case (kind)
            0: begin
                ino = pool_inode[sel];
                fs = pool_fs[sel];
            end
            1: begin
                case ($urandom_range(0, 2))
                    0: ino = '0;
                    1: ino = '1;
                    default: ino = 64'h8000_0000_0000_0000;
                endcase
                fs = $urandom_range(0, 1) ? 8'hff : 8'h00;
            end
            default: begin
                ino = {$urandom, $urandom};
                fs = 8'($urandom_range(0, 255));
            end
        endcase
    endtask

    // weighted mix of all modes over random slots
    task automatic random_mix(input int n);
        int          w;
        logic [2:0]  m;
        logic [63:0] ino;
        logic [7:0]  fs;
        repeat (n) begin
            w = $urandom_range(0, 99);
            if (w < 22) m = MODE_ALLOC;
            else if (w < 42) m = MODE_RELEASE;
            else if (w < 58) m = MODE_PIN;
            else if (w < 74) m = MODE_UNPIN;
            else if (w < 84) m = MODE_LOOKUP;
            else if (w < 96) m = MODE_QUERY;
            else m = w[0] ? MODE_UNDEF_LO : MODE_UNDEF_HI;
            random_payload(m == MODE_QUERY && $urandom_range(0, 9) < 7, ino, fs);
            send_request(m, 6'($urandom_range(0, SLOTS - 1)), ino, fs);
        end
    endtask

    // allocate n times in a row; enough of them run into a full table
    task automatic fill_table(input int n);
        logic [63:0] ino;
        logic [7:0]  fs;
        repeat (n) begin
            random_payload(1'b0, ino, fs);
            send_request(MODE_ALLOC, '0, ino, fs);
        end
    endtask

    // walk every slot: drop one pin, then try to free it
    task automatic drain_table();
        logic [63:0] ino;
        logic [7:0]  fs;
        for (int s = 0; s < SLOTS; s++) begin
            random_payload(1'b0, ino, fs);
            send_request(MODE_UNPIN, 6'(s), ino, fs);
            send_request(MODE_RELEASE, 6'(s), ino, fs);
        end
    endtask

    initial begin
        int          storm_slot;
        int          pick;
        logic [63:0] ino;
        logic [7:0]  fs;

        for (int i = 0; i < 8; i++) mode_count[i] = 0;
        for (int i = 0; i < POOL_DEPTH; i++) begin
            pool_inode[i] = '0;
            pool_fs[i] = '0;
        end

        // hold reset, then release it
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, field extremes, every mode and corner status
        send_request(MODE_LOOKUP, 6'd0, 64'd0, 8'h00);
        send_request(MODE_RELEASE, 6'd63, '1, 8'hff);
        send_request(MODE_PIN, 6'd5, 64'd0, 8'h00);
        send_request(MODE_UNPIN, 6'd5, 64'd0, 8'h00);
        send_request(MODE_QUERY, 6'd0, '1, 8'hff);
        send_request(MODE_ALLOC, 6'd0, 64'd0, 8'h00);
        send_request(MODE_ALLOC, 6'd63, '1, 8'hff);
        send_request(MODE_QUERY, 6'd0, '1, 8'hff);
        send_request(MODE_QUERY, 6'd0, '1, 8'hfe);
        send_request(MODE_QUERY, 6'd63, 64'd0, 8'h00);
        send_request(MODE_LOOKUP, 6'd2, 64'd0, 8'h00);
        send_request(MODE_PIN, 6'd2, 64'd0, 8'h00);
        send_request(MODE_RELEASE, 6'd2, 64'd0, 8'h00);
        send_request(MODE_UNPIN, 6'd2, 64'd0, 8'h00);
        send_request(MODE_UNPIN, 6'd2, 64'd0, 8'h00);
        send_request(MODE_RELEASE, 6'd2, 64'd0, 8'h00);
        send_request(MODE_LOOKUP, 6'd2, 64'd0, 8'h00);
        send_request(MODE_UNDEF_LO, 6'd63, '1, 8'hff);
        send_request(MODE_UNDEF_HI, 6'd0, 64'd0, 8'h00);
        send_request(MODE_ALLOC, 6'd0, 64'h8000_0000_0000_0000, 8'h80);
        send_request(MODE_RELEASE, 6'd1, 64'd0, 8'h00);
        send_request(MODE_ALLOC, 6'd0, 64'h5555_5555_5555_5555, 8'h55);
        send_request(MODE_QUERY, 6'd0, '1, 8'hff);

        // random mix, then fill up until the table reports full
        random_mix(250);
        fill_table(SLOTS + 6);

        // pin storm on one slot of the full table: overflow, then underflow
        storm_slot = $urandom_range(0, SLOTS - 1);
        repeat (PIN_LIMIT + 1) begin
            random_payload(1'b0, ino, fs);
            send_request(MODE_PIN, 6'(storm_slot), ino, fs);
        end
        repeat (PIN_LIMIT + 1) begin
            random_payload(1'b0, ino, fs);
            send_request(MODE_UNPIN, 6'(storm_slot), ino, fs);
        end

        // long result-side hold-off while requests keep coming
        long_hold_req = 1'b1;
        gaps_on = 1'b0;
        random_mix(40);
        gaps_on = 1'b1;
        random_mix(200);

        // sender pause until the engine has returned everything
        wait_results_done();
        drain_table();

        // episodes with idling switched on and off
        while (sent_total < TOTAL_ITEMS - QUIET_TAIL) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 7);
            if (pick == 0) fill_table($urandom_range(10, SLOTS + 4));
            else if (pick == 1) drain_table();
            else random_mix($urandom_range(30, 80));
        end

        // closing stretch at full rate on both sides
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        random_mix(QUIET_TAIL);

        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d requests: alloc %0d, release %0d, pin %0d, unpin %0d,",
                 sent_total, mode_count[MODE_ALLOC], mode_count[MODE_RELEASE],
                 mode_count[MODE_PIN], mode_count[MODE_UNPIN]);
        $display("lookup %0d, query %0d, undefined %0d; %0d result beats compared",
                 mode_count[MODE_LOOKUP], mode_count[MODE_QUERY],
                 mode_count[MODE_UNDEF_LO] + mode_count[MODE_UNDEF_HI], compared);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/dte_pkg.sv
rtl/dte_ctrl.sv
rtl/dte_dp.sv
rtl/descriptor_table_engine.sv
bench/slot_table_checker.sv
bench/tb_descriptor_table_engine.sv
